FILE: rtl/core/arm_thumb_branch_unit_macros.svh
// ----------------------------------------------------------------------------
// arm_thumb_branch_unit assertion macros
// concurrent checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ARM_THUMB_BRANCH_UNIT_MACROS_SVH
`define ARM_THUMB_BRANCH_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define ATBU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("branch unit check failed");
`define ATBU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("branch unit check failed");
`else
`define ATBU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ATBU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/atbu_pkg.sv
// ----------------------------------------------------------------------------
// atbu_pkg
// shared types and codes of the ARM/Thumb branch unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package atbu_pkg;

    localparam logic [3:0] OP_BX       = 4'd0;
    localparam logic [3:0] OP_BLX_REG  = 4'd1;
    localparam logic [3:0] OP_B        = 4'd2;
    localparam logic [3:0] OP_BL       = 4'd3;
    localparam logic [3:0] OP_BLX_IMM  = 4'd4;
    localparam logic [3:0] OP_TB_COND  = 4'd5;
    localparam logic [3:0] OP_TB       = 4'd6;
    localparam logic [3:0] OP_TBX      = 4'd7;
    localparam logic [3:0] OP_TBLX_REG = 4'd8;
    localparam logic [3:0] OP_TBL_HI   = 4'd9;
    localparam logic [3:0] OP_TBL_LO   = 4'd10;
    localparam logic [3:0] OP_TBLX_LO  = 4'd11;

    localparam logic [1:0] COST_TAKEN     = 2'd3;
    localparam logic [1:0] COST_NOT_TAKEN = 2'd1;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [31:0] instr_word;
        logic [31:0] pc_value;
        logic [31:0] reg_value;
        logic [31:0] link_value;
        logic [3:0]  flags_nzcv;
        logic        thumb_in;
    } t_atbu_req;

    typedef struct packed {
        logic [31:0] new_pc;
        logic        pc_write;
        logic [31:0] new_link;
        logic        link_write;
        logic        thumb_out;
        logic [1:0]  cycle_cost;
    } t_atbu_result;

endpackage

FILE: rtl/core/atbu_decode.sv
// ----------------------------------------------------------------------------
// atbu_decode
// branch decode: target, link value, state bit and cycle charge
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atbu_decode (
    input  atbu_pkg::t_atbu_req    i_req,
    output atbu_pkg::t_atbu_result o_result
);

    localparam logic [3:0] COND_EQ = 4'd0;
    localparam logic [3:0] COND_NE = 4'd1;
    localparam logic [3:0] COND_CS = 4'd2;
    localparam logic [3:0] COND_CC = 4'd3;
    localparam logic [3:0] COND_MI = 4'd4;
    localparam logic [3:0] COND_PL = 4'd5;
    localparam logic [3:0] COND_VS = 4'd6;
    localparam logic [3:0] COND_VC = 4'd7;
    localparam logic [3:0] COND_HI = 4'd8;
    localparam logic [3:0] COND_LS = 4'd9;
    localparam logic [3:0] COND_GE = 4'd10;
    localparam logic [3:0] COND_LT = 4'd11;
    localparam logic [3:0] COND_GT = 4'd12;
    localparam logic [3:0] COND_LE = 4'd13;
    localparam logic [3:0] COND_AL = 4'd14;

    logic [31:0] w;
    logic        f_n, f_z, f_c, f_v;
    logic        cond_ok;
    logic [31:0] arm_off;
    logic [31:0] blx_off;
    logic [31:0] tcond_off;
    logic [31:0] tb_off;
    logic [31:0] thi_off;
    logic [31:0] tlo_sum;
    logic [31:0] reg_target;
    logic [31:0] arm_link;
    logic [31:0] thumb_link;

    assign w          = i_req.instr_word;
    assign {f_n, f_z, f_c, f_v} = i_req.flags_nzcv;
    assign arm_off    = {{6{w[23]}}, w[23:0], 2'b00};
    assign blx_off    = {{6{w[23]}}, w[23:0], w[24], 1'b0};
    assign tcond_off  = {{23{w[7]}}, w[7:0], 1'b0};
    assign tb_off     = {{20{w[10]}}, w[10:0], 1'b0};
    assign thi_off    = {{9{w[10]}}, w[10:0], 12'h000};
    assign tlo_sum    = i_req.link_value + {20'h00000, w[10:0], 1'b0};
    assign reg_target = {i_req.reg_value[31:1], 1'b0};
    assign arm_link   = i_req.pc_value - 32'd4;
    assign thumb_link = i_req.pc_value - 32'd1;

    always_comb begin
        case (w[11:8])
            COND_EQ: cond_ok = f_z;
            COND_NE: cond_ok = !f_z;
            COND_CS: cond_ok = f_c;
            COND_CC: cond_ok = !f_c;
            COND_MI: cond_ok = f_n;
            COND_PL: cond_ok = !f_n;
            COND_VS: cond_ok = f_v;
            COND_VC: cond_ok = !f_v;
            COND_HI: cond_ok = f_c && !f_z;
            COND_LS: cond_ok = !f_c || f_z;
            COND_GE: cond_ok = (f_n == f_v);
            COND_LT: cond_ok = (f_n != f_v);
            COND_GT: cond_ok = !f_z && (f_n == f_v);
            COND_LE: cond_ok = f_z || (f_n != f_v);
            COND_AL: cond_ok = 1'b1;
            default: cond_ok = 1'b0;
        endcase
    end

    always_comb begin
        o_result.new_pc     = 32'h0;
        o_result.pc_write   = 1'b0;
        o_result.new_link   = 32'h0;
        o_result.link_write = 1'b0;
        o_result.thumb_out  = i_req.thumb_in;
        case (i_req.opcode)
            atbu_pkg::OP_BX, atbu_pkg::OP_TBX: begin
                o_result.new_pc    = reg_target;
                o_result.pc_write  = 1'b1;
                o_result.thumb_out = i_req.reg_value[0];
            end
            atbu_pkg::OP_BLX_REG: begin
                o_result.new_pc     = reg_target;
                o_result.pc_write   = 1'b1;
                o_result.thumb_out  = i_req.reg_value[0];
                o_result.new_link   = arm_link;
                o_result.link_write = 1'b1;
            end
            atbu_pkg::OP_B: begin
                o_result.new_pc   = i_req.pc_value + arm_off;
                o_result.pc_write = 1'b1;
            end
            atbu_pkg::OP_BL: begin
                o_result.new_pc     = i_req.pc_value + arm_off;
                o_result.pc_write   = 1'b1;
                o_result.new_link   = arm_link;
                o_result.link_write = 1'b1;
            end
            atbu_pkg::OP_BLX_IMM: begin
                o_result.new_pc     = i_req.pc_value + blx_off;
                o_result.pc_write   = 1'b1;
                o_result.new_link   = arm_link;
                o_result.link_write = 1'b1;
                o_result.thumb_out  = 1'b1;
            end
            atbu_pkg::OP_TB_COND: begin
                if (cond_ok) begin
                    o_result.new_pc   = i_req.pc_value + tcond_off;
                    o_result.pc_write = 1'b1;
                end
            end
            atbu_pkg::OP_TB: begin
                o_result.new_pc   = i_req.pc_value + tb_off;
                o_result.pc_write = 1'b1;
            end
            atbu_pkg::OP_TBLX_REG: begin
                o_result.new_pc     = reg_target;
                o_result.pc_write   = 1'b1;
                o_result.thumb_out  = i_req.reg_value[0];
                o_result.new_link   = thumb_link;
                o_result.link_write = 1'b1;
            end
            atbu_pkg::OP_TBL_HI: begin
                o_result.new_link   = i_req.pc_value + thi_off;
                o_result.link_write = 1'b1;
            end
            atbu_pkg::OP_TBL_LO: begin
                o_result.new_pc     = tlo_sum;
                o_result.pc_write   = 1'b1;
                o_result.new_link   = thumb_link;
                o_result.link_write = 1'b1;
            end
            atbu_pkg::OP_TBLX_LO: begin
                o_result.new_pc     = {tlo_sum[31:2], 2'b00};
                o_result.pc_write   = 1'b1;
                o_result.new_link   = thumb_link;
                o_result.link_write = 1'b1;
                o_result.thumb_out  = 1'b0;
            end
            default: begin
                o_result.pc_write = 1'b0;
            end
        endcase
        o_result.cycle_cost = o_result.pc_write ? atbu_pkg::COST_TAKEN
                                                : atbu_pkg::COST_NOT_TAKEN;
    end

endmodule

FILE: rtl/core/arm_thumb_branch_unit.sv
// ----------------------------------------------------------------------------
// arm_thumb_branch_unit: ARM/Thumb branch resolution
// pipeline: request register, decode and add (single stage), result register
// one request per cycle while the output side is not stalled
// synchronous active-low reset clears both stage valid flags
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "arm_thumb_branch_unit_macros.svh"

module arm_thumb_branch_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_opcode,
    input  logic [31:0] i_instr_word,
    input  logic [31:0] i_pc_value,
    input  logic [31:0] i_reg_value,
    input  logic [31:0] i_link_value,
    input  logic [3:0]  i_flags_nzcv,
    input  logic        i_thumb_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_new_pc,
    output logic        o_pc_write,
    output logic [31:0] o_new_link,
    output logic        o_link_write,
    output logic        o_thumb_out,
    output logic [1:0]  o_cycle_cost
);

    logic                   r_in_vld;
    atbu_pkg::t_atbu_req    r_req;
    logic                   r_out_vld;
    atbu_pkg::t_atbu_result r_res;
    atbu_pkg::t_atbu_result n_res;
    logic                   out_adv;
    logic                   in_take;

    assign out_adv    = !r_out_vld || i_out_ready;
    assign o_in_ready = !r_in_vld || out_adv;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (out_adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req.opcode     <= i_opcode;
            r_req.instr_word <= i_instr_word;
            r_req.pc_value   <= i_pc_value;
            r_req.reg_value  <= i_reg_value;
            r_req.link_value <= i_link_value;
            r_req.flags_nzcv <= i_flags_nzcv;
            r_req.thumb_in   <= i_thumb_in;
        end
        if (out_adv && r_in_vld) begin
            r_res <= n_res;
        end
    end

    atbu_decode u_decode (
        .i_req    (r_req),
        .o_result (n_res)
    );

    assign o_out_valid  = r_out_vld;
    assign o_new_pc     = r_res.new_pc;
    assign o_pc_write   = r_res.pc_write;
    assign o_new_link   = r_res.new_link;
    assign o_link_write = r_res.link_write;
    assign o_thumb_out  = r_res.thumb_out;
    assign o_cycle_cost = r_res.cycle_cost;

    // stalled request is never dropped
    `ATBU_ASSERT_NEXT(a_req_held, i_clk, i_rst_n, r_in_vld && !out_adv, r_in_vld)
    // charge follows the pc strobe
    `ATBU_ASSERT_IMPLY(a_cost_match, i_clk, i_rst_n, o_out_valid,
        (o_pc_write && o_cycle_cost == atbu_pkg::COST_TAKEN) ||
        (!o_pc_write && o_cycle_cost == atbu_pkg::COST_NOT_TAKEN))
    // unwritten values read as zero
    `ATBU_ASSERT_IMPLY(a_zero_unwritten, i_clk, i_rst_n, o_out_valid,
        (o_pc_write || o_new_pc == 32'h0) && (o_link_write || o_new_link == 32'h0))

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for arm_thumb_branch_unit
// feeds ARM and Thumb branch requests through the valid/ready input, predicts
// each resolution (target, link, Thumb bit, cycle charge) and compares it with
// the returned result in order; random idle and stall bursts on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam logic [3:0] OP_UNUSED_FIRST = 4'd12;
    localparam logic [3:0] OP_UNUSED_LAST  = 4'd15;

    typedef enum logic [3:0] {
        CC_EQ, CC_NE, CC_CS, CC_CC, CC_MI, CC_PL, CC_VS, CC_VC,
        CC_HI, CC_LS, CC_GE, CC_LT, CC_GT, CC_LE, CC_AL, CC_NV
    } t_cond;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [3:0]  i_opcode = '0;
    logic [31:0] i_instr_word = '0;
    logic [31:0] i_pc_value = '0;
    logic [31:0] i_reg_value = '0;
    logic [31:0] i_link_value = '0;
    logic [3:0]  i_flags_nzcv = '0;
    logic        i_thumb_in = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_new_pc;
    logic        o_pc_write;
    logic [31:0] o_new_link;
    logic        o_link_write;
    logic        o_thumb_out;
    logic [1:0]  o_cycle_cost;

    atbu_pkg::t_atbu_req    pending_reqs[$];
    atbu_pkg::t_atbu_result expected_results[$];
    atbu_pkg::t_atbu_req    active_req;
    bit           steady_tail = 1'b0;
    int           send_idle_left = 0;
    int           recv_stall_left = 0;
    int           error_count = 0;
    int           requests_sent = 0;
    int           results_checked = 0;
    int           cond_taken = 0;
    int           cond_skipped = 0;

    arm_thumb_branch_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_instr_word (i_instr_word),
        .i_pc_value   (i_pc_value),
        .i_reg_value  (i_reg_value),
        .i_link_value (i_link_value),
        .i_flags_nzcv (i_flags_nzcv),
        .i_thumb_in   (i_thumb_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_new_pc     (o_new_pc),
        .o_pc_write   (o_pc_write),
        .o_new_link   (o_new_link),
        .o_link_write (o_link_write),
        .o_thumb_out  (o_thumb_out),
        .o_cycle_cost (o_cycle_cost)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic bit cond_holds(input t_cond cc, input logic [3:0] nzcv);
        logic n, z, c, v;
        bit   hit;
        {n, z, c, v} = nzcv;
        case (cc)
            CC_EQ: hit = z;
            CC_NE: hit = !z;
            CC_CS: hit = c;
            CC_CC: hit = !c;
            CC_MI: hit = n;
            CC_PL: hit = !n;
            CC_VS: hit = v;
            CC_VC: hit = !v;
            CC_HI: hit = c && !z;
            CC_LS: hit = !c || z;
            CC_GE: hit = (n == v);
            CC_LT: hit = (n != v);
            CC_GT: hit = !z && (n == v);
            CC_LE: hit = z || (n != v);
            CC_AL: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic atbu_pkg::t_atbu_result resolve_branch(input atbu_pkg::t_atbu_req req);
        atbu_pkg::t_atbu_result res;
        logic [31:0]  w;
        logic [31:0]  arm_off;
        logic [31:0]  far_sum;
        res = '0;
        res.thumb_out = req.thumb_in;
        w = req.instr_word;
        arm_off = {{6{w[23]}}, w[23:0], 2'b00};
        far_sum = req.link_value + {20'b0, w[10:0], 1'b0};
        case (req.opcode)
            atbu_pkg::OP_BX, atbu_pkg::OP_TBX, atbu_pkg::OP_BLX_REG,
            atbu_pkg::OP_TBLX_REG: begin
                res.new_pc    = {req.reg_value[31:1], 1'b0};
                res.pc_write  = 1'b1;
                res.thumb_out = req.reg_value[0];
                if (req.opcode == atbu_pkg::OP_BLX_REG) begin
                    res.new_link   = req.pc_value - 32'd4;
                    res.link_write = 1'b1;
                end else if (req.opcode == atbu_pkg::OP_TBLX_REG) begin
                    res.new_link   = req.pc_value - 32'd1;
                    res.link_write = 1'b1;
                end
            end
            atbu_pkg::OP_B, atbu_pkg::OP_BL: begin
                res.new_pc   = req.pc_value + arm_off;
                res.pc_write = 1'b1;
                if (req.opcode == atbu_pkg::OP_BL) begin
                    res.new_link   = req.pc_value - 32'd4;
                    res.link_write = 1'b1;
                end
            end
            atbu_pkg::OP_BLX_IMM: begin
                res.new_pc     = req.pc_value + (arm_off | {30'b0, w[24], 1'b0});
                res.pc_write   = 1'b1;
                res.new_link   = req.pc_value - 32'd4;
                res.link_write = 1'b1;
                res.thumb_out  = 1'b1;
            end
            atbu_pkg::OP_TB_COND: begin
                if (cond_holds(t_cond'(w[11:8]), req.flags_nzcv)) begin
                    res.new_pc   = req.pc_value + {{23{w[7]}}, w[7:0], 1'b0};
                    res.pc_write = 1'b1;
                end
            end
            atbu_pkg::OP_TB: begin
                res.new_pc   = req.pc_value + {{20{w[10]}}, w[10:0], 1'b0};
                res.pc_write = 1'b1;
            end
            atbu_pkg::OP_TBL_HI: begin
                res.new_link   = req.pc_value + {{9{w[10]}}, w[10:0], 12'b0};
                res.link_write = 1'b1;
            end
            atbu_pkg::OP_TBL_LO, atbu_pkg::OP_TBLX_LO: begin
                res.new_pc     = far_sum;
                res.pc_write   = 1'b1;
                res.new_link   = req.pc_value - 32'd1;
                res.link_write = 1'b1;
                if (req.opcode == atbu_pkg::OP_TBLX_LO) begin
                    res.new_pc    = {far_sum[31:2], 2'b00};
                    res.thumb_out = 1'b0;
                end
            end
            default: ;
        endcase
        res.cycle_cost = res.pc_write ? atbu_pkg::COST_TAKEN : atbu_pkg::COST_NOT_TAKEN;
        return res;
    endfunction

    function automatic atbu_pkg::t_atbu_req make_req(input logic [3:0] op,
                                                     input logic [31:0] w,
                                                     input logic [31:0] pc,
                                                     input logic [31:0] rv,
                                                     input logic [31:0] lr,
                                                     input logic [3:0] fl,
                                                     input logic t);
        atbu_pkg::t_atbu_req req;
        req.opcode     = op;
        req.instr_word = w;
        req.pc_value   = pc;
        req.reg_value  = rv;
        req.link_value = lr;
        req.flags_nzcv = fl;
        req.thumb_in   = t;
        return req;
    endfunction

    function automatic logic [31:0] edgy_word();
        logic [31:0] val;
        case ($urandom_range(0, 7))
            0: val = 32'h0000_0000;
            1: val = 32'hFFFF_FFFF;
            2: val = 32'h8000_0000;
            3: val = 32'h7FFF_FFFF;
            default: val = $urandom;
        endcase
        return val;
    endfunction

    function automatic atbu_pkg::t_atbu_req random_req();
        logic [3:0] op;
        if ($urandom_range(0, 15) == 0)
            op = 4'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        else
            op = 4'($urandom_range(atbu_pkg::OP_BX, atbu_pkg::OP_TBLX_LO));
        return make_req(op, edgy_word(), edgy_word(), edgy_word(), edgy_word(),
                        4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endfunction

    // thumb long branches mostly come as a first half followed by its second half
    task automatic queue_random(input int count);
        int                  n;
        atbu_pkg::t_atbu_req head;
        atbu_pkg::t_atbu_req tail;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 5) == 0) begin
                head = make_req(atbu_pkg::OP_TBL_HI, $urandom, $urandom, $urandom, $urandom,
                                4'($urandom_range(0, 15)), 1'b1);
                tail = make_req($urandom_range(0, 1) ? atbu_pkg::OP_TBL_LO
                                                     : atbu_pkg::OP_TBLX_LO,
                                $urandom, head.pc_value + 32'd2, $urandom,
                                resolve_branch(head).new_link, head.flags_nzcv, 1'b1);
                pending_reqs.push_back(head);
                pending_reqs.push_back(tail);
                n += 2;
            end else begin
                pending_reqs.push_back(random_req());
                n++;
            end
        end
    endtask

    task automatic wait_for_drain();
        while (pending_reqs.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // request side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(resolve_branch(active_req));
                requests_sent++;
                if (active_req.opcode == atbu_pkg::OP_TB_COND) begin
                    if (resolve_branch(active_req).pc_write)
                        cond_taken++;
                    else
                        cond_skipped++;
                end
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_idle_left > 0) begin
                    send_idle_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    active_req = pending_reqs.pop_front();
                    i_opcode     <= active_req.opcode;
                    i_instr_word <= active_req.instr_word;
                    i_pc_value   <= active_req.pc_value;
                    i_reg_value  <= active_req.reg_value;
                    i_link_value <= active_req.link_value;
                    i_flags_nzcv <= active_req.flags_nzcv;
                    i_thumb_in   <= active_req.thumb_in;
                    i_in_valid   <= 1'b1;
                    if (!steady_tail && $urandom_range(0, 7) == 0)
                        send_idle_left = $urandom_range(1, 16);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge i_clk) begin
        atbu_pkg::t_atbu_result exp_res;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding");
                    error_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    results_checked++;
                    if (o_new_pc !== exp_res.new_pc) begin
                        $error("new_pc: expected %h, got %h", exp_res.new_pc, o_new_pc);
                        error_count++;
                    end
                    if (o_pc_write !== exp_res.pc_write) begin
                        $error("pc_write: expected %b, got %b", exp_res.pc_write, o_pc_write);
                        error_count++;
                    end
                    if (o_new_link !== exp_res.new_link) begin
                        $error("new_link: expected %h, got %h", exp_res.new_link, o_new_link);
                        error_count++;
                    end
                    if (o_link_write !== exp_res.link_write) begin
                        $error("link_write: expected %b, got %b",
                               exp_res.link_write, o_link_write);
                        error_count++;
                    end
                    if (o_thumb_out !== exp_res.thumb_out) begin
                        $error("thumb_out: expected %b, got %b", exp_res.thumb_out, o_thumb_out);
                        error_count++;
                    end
                    if (o_cycle_cost !== exp_res.cycle_cost) begin
                        $error("cycle_cost: expected %0d, got %0d",
                               exp_res.cycle_cost, o_cycle_cost);
                        error_count++;
                    end
                end
            end
            if (recv_stall_left > 0) begin
                recv_stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!steady_tail && $urandom_range(0, 7) == 0)
                    recv_stall_left = $urandom_range(1, 16);
            end
        end
    end

    initial begin
        // corner requests: every kind, offset extremes, address wrap, always/never
        pending_reqs.push_back(make_req(atbu_pkg::OP_BX, 32'h0, 32'h0, 32'hFFFF_FFFF,
                                        32'h0, 4'h0, 1'b0));
        pending_reqs.push_back(make_req(atbu_pkg::OP_BX, 32'hFFFF_FFFF, 32'h4, 32'h0,
                                        32'h0, 4'hF, 1'b1));
        pending_reqs.push_back(make_req(atbu_pkg::OP_BLX_REG, 32'h0, 32'h0, 32'h8000_0001,
                                        32'h0, 4'h0, 1'b0));
        pending_reqs.push_back(make_req(atbu_pkg::OP_B, 32'h007F_FFFF, 32'hFFFF_FFF8,
                                        32'h0, 32'h0, 4'h0, 1'b0));
        pending_reqs.push_back(make_req(atbu_pkg::OP_B, 32'hFF80_0000, 32'h0, 32'h0,
                                        32'h0, 4'h0, 1'b0));
        pending_reqs.push_back(make_req(atbu_pkg::OP_BL, 32'h0, 32'h8, 32'h0, 32'h0,
                                        4'h0, 1'b0));
        pending_reqs.push_back(make_req(atbu_pkg::OP_BLX_IMM, 32'h01FF_FFFF, 32'h1000_0000,
                                        32'h0, 32'h0, 4'h0, 1'b0));
        pending_reqs.push_back(make_req(atbu_pkg::OP_BLX_IMM, 32'hFE80_0000, 32'h2, 32'h0,
                                        32'h0, 4'h0, 1'b0));
        pending_reqs.push_back(make_req(atbu_pkg::OP_TB_COND, {20'h0, CC_AL, 8'h7F},
                                        32'h100, 32'h0, 32'h0, 4'h0, 1'b1));
        pending_reqs.push_back(make_req(atbu_pkg::OP_TB_COND, {20'hFFFFF, CC_NV, 8'h80},
                                        32'h100, 32'h0, 32'h0, 4'hF, 1'b1));
        pending_reqs.push_back(make_req(atbu_pkg::OP_TB_COND, {20'h0, CC_EQ, 8'h80},
                                        32'h0, 32'h0, 32'h0, 4'b0100, 1'b1));
        pending_reqs.push_back(make_req(atbu_pkg::OP_TB_COND, {20'h0, CC_GT, 8'h01},
                                        32'h40, 32'h0, 32'h0, 4'b1001, 1'b1));
        pending_reqs.push_back(make_req(atbu_pkg::OP_TB_COND, {20'h0, CC_LE, 8'h01},
                                        32'h40, 32'h0, 32'h0, 4'b1001, 1'b1));
        pending_reqs.push_back(make_req(atbu_pkg::OP_TB, 32'h0000_03FF, 32'hFFFF_FFFE,
                                        32'h0, 32'h0, 4'h0, 1'b1));
        pending_reqs.push_back(make_req(atbu_pkg::OP_TB, 32'hFFFF_0400, 32'h0, 32'h0,
                                        32'h0, 4'h0, 1'b1));
        pending_reqs.push_back(make_req(atbu_pkg::OP_TBX, 32'h0, 32'h0, 32'h1, 32'h0,
                                        4'h0, 1'b1));
        pending_reqs.push_back(make_req(atbu_pkg::OP_TBLX_REG, 32'h0, 32'h0, 32'hFFFF_FFFE,
                                        32'h0, 4'h0, 1'b1));
        pending_reqs.push_back(make_req(atbu_pkg::OP_TBL_HI, 32'h0000_0400, 32'h0, 32'h0,
                                        32'h0, 4'h0, 1'b1));
        pending_reqs.push_back(make_req(atbu_pkg::OP_TBL_HI, 32'h0000_03FF, 32'hFFFF_FFFF,
                                        32'h0, 32'h0, 4'h0, 1'b1));
        pending_reqs.push_back(make_req(atbu_pkg::OP_TBL_LO, 32'h0000_07FF, 32'h0, 32'h0,
                                        32'hFFFF_FFFF, 4'h0, 1'b1));
        pending_reqs.push_back(make_req(atbu_pkg::OP_TBLX_LO, 32'hFFFF_FFFF, 32'h2, 32'h0,
                                        32'h0000_0003, 4'h0, 1'b1));
        pending_reqs.push_back(make_req(OP_UNUSED_FIRST, 32'h0, 32'h0, 32'h0, 32'h0,
                                        4'h0, 1'b0));
        pending_reqs.push_back(make_req(OP_UNUSED_LAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 1'b1));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_random(450);
        wait_for_drain();
        queue_random(450);
        while (pending_reqs.size() != 0)
            @(posedge i_clk);
        steady_tail = 1'b1;
        queue_random(150);
        wait_for_drain();
        repeat (6) @(posedge i_clk);

        $display("checked %0d of %0d branch requests across all kinds and unused codes",
                 results_checked, requests_sent);
        $display("thumb conditional branches: %0d taken, %0d not taken",
                 cond_taken, cond_skipped);
        if (error_count == 0 && expected_results.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

FILE: arm_thumb_branch_unit.f
+incdir+rtl/core
rtl/core/atbu_pkg.sv
rtl/core/atbu_decode.sv
rtl/core/arm_thumb_branch_unit.sv
bench/tb_top.sv
